// File: hdl/obwpt_pkg.sv
// ----------------------------------------------------------------------------
// obwpt_pkg
// Shared constants and types of the output bank with pulse timers.
// ----------------------------------------------------------------------------
package obwpt_pkg;

   localparam int DEFAULT_NUM_OUTPUTS = 8;
   localparam int DEFAULT_COUNT_BITS  = 16;

   localparam int TYPE_BITS  = 3;
   localparam int INDEX_BITS = 3;
   localparam int TICKS_BITS = 16;
   localparam int PIN_BITS   = 8;
   localparam int MASK_BITS  = 8;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register index, taken from paddr[2]
   localparam logic REG_INVERT_MASK = 1'b0;

   // request codes
   localparam logic [TYPE_BITS-1:0] REQ_SET    = 3'd0;
   localparam logic [TYPE_BITS-1:0] REQ_TOGGLE = 3'd1;
   localparam logic [TYPE_BITS-1:0] REQ_PULSE  = 3'd2;
   localparam logic [TYPE_BITS-1:0] REQ_GET    = 3'd3;
   localparam logic [TYPE_BITS-1:0] REQ_TICK   = 3'd4;

   typedef struct packed {
      logic [TYPE_BITS-1:0]  req_type;
      logic [INDEX_BITS-1:0] output_index;
      logic                  level;
      logic [TICKS_BITS-1:0] pulse_ticks;
   } request_type;

   typedef struct packed {
      logic [PIN_BITS-1:0] pin_levels;
      logic                read_level;
      logic                pulse_running;
   } result_type;

endpackage

// File: hdl/obwpt_if.sv
// ----------------------------------------------------------------------------
// obwpt_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface obwpt_req_if
   import obwpt_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [TYPE_BITS-1:0]  req_type;
   logic [INDEX_BITS-1:0] output_index;
   logic                  level;
   logic [TICKS_BITS-1:0] pulse_ticks;

   modport source (output valid, output req_type, output output_index, output level,
                   output pulse_ticks, input ready);
   modport sink   (input valid, input req_type, input output_index, input level,
                   input pulse_ticks, output ready);
endinterface

interface obwpt_rsp_if
   import obwpt_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [PIN_BITS-1:0] pin_levels;
   logic                read_level;
   logic                pulse_running;

   modport source (output valid, output pin_levels, output read_level,
                   output pulse_running, input ready);
   modport sink   (input valid, input pin_levels, input read_level,
                   input pulse_running, output ready);
endinterface

// File: hdl/obwpt_csr.sv
// ----------------------------------------------------------------------------
// obwpt_csr
// APB register port holding the pin invert mask.
// ----------------------------------------------------------------------------
module obwpt_csr
   import obwpt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [MASK_BITS-1:0]     invert_mask
);

   logic [MASK_BITS-1:0] invert_mask_ff;
   logic [MASK_BITS-1:0] invert_mask_in;
   logic                 wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_INVERT_MASK);

   assign invert_mask_in = wr_en ? pwdata[MASK_BITS-1:0] : invert_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_mask_ff <= '0;
      end else begin
         invert_mask_ff <= invert_mask_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_INVERT_MASK) begin
         prdata[MASK_BITS-1:0] = invert_mask_ff;
      end
   end

   assign invert_mask = invert_mask_ff;

endmodule

// File: hdl/obwpt_core.sv
// ----------------------------------------------------------------------------
// obwpt_core
// Output levels and pulse counters; applies one request per fire.
// ----------------------------------------------------------------------------
module obwpt_core
   import obwpt_pkg::*;
#(
   parameter int NUM_OUTPUTS = DEFAULT_NUM_OUTPUTS,
   parameter int COUNT_BITS  = DEFAULT_COUNT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  request_type          req,
   input  logic [MASK_BITS-1:0] invert_mask,
   output result_type           result
);

   localparam int IDX_BITS = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

   logic [NUM_OUTPUTS-1:0] levels_ff;
   logic [NUM_OUTPUTS-1:0] levels_in;
   logic [COUNT_BITS-1:0]  counters_ff [NUM_OUTPUTS];
   logic [COUNT_BITS-1:0]  counters_in [NUM_OUTPUTS];

   logic [COUNT_BITS-1:0]  load_value;
   logic [IDX_BITS-1:0]    idx;
   logic                   idx_ok;
   logic [PIN_BITS-1:0]    pins;

   assign idx    = IDX_BITS'(req.output_index);
   assign idx_ok = 32'(req.output_index) < NUM_OUTPUTS;

   // saturate the pulse length to the counter range
   generate
      if (COUNT_BITS < TICKS_BITS) begin : g_sat
         assign load_value = (|req.pulse_ticks[TICKS_BITS-1:COUNT_BITS]) ?
                             '1 : req.pulse_ticks[COUNT_BITS-1:0];
      end else begin : g_nosat
         assign load_value = COUNT_BITS'(req.pulse_ticks);
      end
   endgenerate

   always_comb begin
      levels_in = levels_ff;
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
         counters_in[i] = counters_ff[i];
      end
      if (req.req_type == REQ_TICK) begin
         for (int i = 0; i < NUM_OUTPUTS; i++) begin
            if (counters_ff[i] != '0) begin
               counters_in[i] = counters_ff[i] - COUNT_BITS'(1);
               if (counters_ff[i] == COUNT_BITS'(1)) begin
                  levels_in[i] = ~levels_ff[i];
               end
            end
         end
      end else if (idx_ok) begin
         priority if (req.req_type == REQ_SET) begin
            levels_in[idx] = req.level;
         end else if (req.req_type == REQ_TOGGLE) begin
            levels_in[idx] = ~levels_ff[idx];
         end else if (req.req_type == REQ_PULSE && req.pulse_ticks != '0) begin
            if (counters_ff[idx] == '0) begin
               levels_in[idx] = ~levels_ff[idx];
            end
            counters_in[idx] = load_value;
         end else begin
            levels_in = levels_ff;
         end
      end
   end

   generate
      for (genvar b = 0; b < PIN_BITS; b++) begin : g_pin
         if (b < NUM_OUTPUTS) begin : g_on
            assign pins[b] = levels_in[b] ^ invert_mask[b];
         end else begin : g_off
            assign pins[b] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      result.pin_levels    = pins;
      result.read_level    = idx_ok ? levels_in[idx] : 1'b0;
      result.pulse_running = idx_ok ? (counters_in[idx] != '0) : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= '0;
         for (int i = 0; i < NUM_OUTPUTS; i++) begin
            counters_ff[i] <= '0;
         end
      end else if (fire) begin
         levels_ff <= levels_in;
         for (int i = 0; i < NUM_OUTPUTS; i++) begin
            counters_ff[i] <= counters_in[i];
         end
      end
   end

endmodule

// File: hdl/output_bank_with_pulse_timers.sv
// ----------------------------------------------------------------------------
// output_bank_with_pulse_timers
// GPIO output bank with retriggerable one-shot pulse timers per output.
//
//   channel   kind        handshake       payload
//   req_chan  input       valid/ready     req_type, output_index, level, pulse_ticks
//   rsp_chan  output      valid/ready     pin_levels, read_level, pulse_running
//   csr_*     APB slave   psel/penable    invert_mask at address 0
//
// One request per cycle while the result does not stall; each request passes
// the input register, then the state update into the result register.
// All counters step in parallel on a tick, in one state update.
// Reset is synchronous and clears levels, counters and the invert mask.
// A stalled result holds the input register, which then drops req ready.
// ----------------------------------------------------------------------------
module output_bank_with_pulse_timers
   import obwpt_pkg::*;
#(
   parameter int NUM_OUTPUTS = DEFAULT_NUM_OUTPUTS,
   parameter int COUNT_BITS  = DEFAULT_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   obwpt_req_if.sink                req_chan,
   obwpt_rsp_if.source              rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   request_type          s1_req_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   result_type           rsp_ff;
   result_type           core_result;
   logic [MASK_BITS-1:0] invert_mask;
   logic                 advance;
   logic                 accept;
   logic                 fire;

   obwpt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .invert_mask (invert_mask)
   );

   obwpt_core #(
      .NUM_OUTPUTS (NUM_OUTPUTS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .req         (s1_req_ff),
      .invert_mask (invert_mask),
      .result      (core_result)
   );

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign fire           = s1_valid_ff && advance;

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff.req_type     <= req_chan.req_type;
         s1_req_ff.output_index <= req_chan.output_index;
         s1_req_ff.level        <= req_chan.level;
         s1_req_ff.pulse_ticks  <= req_chan.pulse_ticks;
      end
      if (fire) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pin_levels    = rsp_ff.pin_levels;
   assign rsp_chan.read_level    = rsp_ff.read_level;
   assign rsp_chan.pulse_running = rsp_ff.pulse_running;

   // assertions
   a_ready_low_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_chan.ready))
      else $error("request ready low without a full pipeline");

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed request produced no result");

   a_pulse_runs: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_req_ff.req_type == REQ_PULSE && s1_req_ff.pulse_ticks != '0 &&
       32'(s1_req_ff.output_index) < NUM_OUTPUTS) |=> rsp_ff.pulse_running)
      else $error("pulse request did not start its counter");

endmodule
